>>> src/cmow_pkg.sv
// ----------------------------------------------------------------------------
// cmow_pkg
// Shared widths and register map of the clipped Morton order walker.
// ----------------------------------------------------------------------------
package cmow_pkg;

    localparam int DIM_W      = 16;   // width / height register and coordinate ports
    localparam int ADDR_W     = 32;   // raster address and order number
    localparam int MUL_W      = 17;   // shared multiplier operand width
    localparam int PROD_W     = 2 * MUL_W;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 2 * DIM_W + 2 * ADDR_W;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

endpackage

>>> src/clipped_morton_order_walker.sv
// ----------------------------------------------------------------------------
// clipped_morton_order_walker
// Steps: accept, total, check, search (a step per skipped outside block), address;
//   a walk already done ends at the check step, and an earlier result still waiting holds
//   the item. A new item is taken only once the last one is through, set by a single
//   skip unit and one shared 17x17 multiplier (rectangle size, raster address)
// Reset: synchronous active low; width and height return to 1, the walk
//   restarts at scan position zero, no result pending.
// ----------------------------------------------------------------------------
module clipped_morton_order_walker #(
    parameter int COORD_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // apb configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cmow_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [cmow_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cmow_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // request items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [cmow_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // restart, zero fill
    // result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [cmow_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // pos_x, pos_y, raster_addr, order_num
    output logic                              m_axis_tlast,   // is_last
    output logic                              m_axis_tuser    // done_res
);

    localparam int SW = 2 * COORD_BITS + 1;
    localparam int CW = COORD_BITS + 1;
    localparam logic [CW-1:0] DIM_MAX = CW'(1) << COORD_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TOT  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_SRCH = 3'd3;
    localparam logic [2:0] S_ADDR = 3'd4;

    logic [2:0]                       r_state, n_state;
    logic [cmow_pkg::DIM_W-1:0]       r_width;
    logic [cmow_pkg::DIM_W-1:0]       r_height;
    logic [SW-1:0]                    r_scan, n_scan;
    logic [cmow_pkg::ADDR_W-1:0]      r_emit, n_emit;
    logic                             r_fin, n_fin;
    logic [cmow_pkg::PROD_W-1:0]      r_prod;
    logic [cmow_pkg::PROD_W-1:0]      r_total, n_total;
    logic [COORD_BITS-1:0]            r_x, n_x;
    logic [COORD_BITS-1:0]            r_y, n_y;
    logic                             r_ovalid, n_ovalid;
    logic [cmow_pkg::OUT_DATA_W-1:0]  r_odata, n_odata;
    logic                             r_olast, n_olast;
    logic                             r_odone, n_odone;

    logic                             cfg_wr;
    logic                             in_acc;
    logic                             out_free;
    logic [CW-1:0]                    ew;
    logic [CW-1:0]                    eh;
    logic [cmow_pkg::MUL_W-1:0]       mul_a;
    logic [cmow_pkg::MUL_W-1:0]       mul_b;
    logic [COORD_BITS-1:0]            sk_x;
    logic [COORD_BITS-1:0]            sk_y;
    logic                             sk_inside;
    logic [SW-1:0]                    sk_next;
    logic [cmow_pkg::ADDR_W-1:0]      emit_inc;
    logic [cmow_pkg::ADDR_W-1:0]      raster;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            cmow_pkg::REG_WIDTH:  prdata = cmow_pkg::APB_DATA_W'(r_width);
            cmow_pkg::REG_HEIGHT: prdata = cmow_pkg::APB_DATA_W'(r_height);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= cmow_pkg::DIM_W'(1);
            r_height <= cmow_pkg::DIM_W'(1);
        end else if (cfg_wr) begin
            if (paddr[2] == cmow_pkg::REG_WIDTH) begin
                r_width <= pwdata[cmow_pkg::DIM_W-1:0];
            end else begin
                r_height <= pwdata[cmow_pkg::DIM_W-1:0];
            end
        end
    end

    // clipped size
    assign ew = ({1'b0, r_width} > (cmow_pkg::DIM_W + 1)'(DIM_MAX)) ? DIM_MAX : CW'(r_width);
    assign eh = ({1'b0, r_height} > (cmow_pkg::DIM_W + 1)'(DIM_MAX)) ? DIM_MAX : CW'(r_height);

    cmow_skip #(
        .COORD_BITS (COORD_BITS)
    ) u_skip (
        .i_scan   (r_scan),
        .i_ew     (ew),
        .i_eh     (eh),
        .o_x      (sk_x),
        .o_y      (sk_y),
        .o_inside (sk_inside),
        .o_next   (sk_next)
    );

    // shared multiplier: size while checking, row times width while searching
    always_comb begin
        if (r_state == S_SRCH) begin
            mul_a = cmow_pkg::MUL_W'(sk_y);
            mul_b = cmow_pkg::MUL_W'(r_width);
        end else begin
            mul_a = cmow_pkg::MUL_W'(ew);
            mul_b = cmow_pkg::MUL_W'(eh);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // a result still waiting holds the item in its check or search step
    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign emit_inc      = r_emit + 1'b1;
    assign raster        = r_prod[cmow_pkg::ADDR_W-1:0] + cmow_pkg::ADDR_W'(r_x);

    always_comb begin
        n_state  = r_state;
        n_scan   = r_scan;
        n_emit   = r_emit;
        n_fin    = r_fin;
        n_total  = r_total;
        n_x      = r_x;
        n_y      = r_y;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        n_olast  = r_olast;
        n_odone  = r_odone;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tdata[0]) begin
                        n_scan = '0;
                        n_emit = '0;
                        n_fin  = 1'b0;
                    end
                    n_state = S_TOT;
                end
            end
            S_TOT: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                n_total = r_prod;
                if (r_fin || ({2'b00, r_emit} >= r_prod)) begin
                    if (out_free) begin
                        n_fin    = 1'b1;
                        n_ovalid = 1'b1;
                        n_odata  = '0;
                        n_olast  = 1'b0;
                        n_odone  = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (r_scan[SW-1]) begin
                    // scan space exhausted
                    if (out_free) begin
                        n_fin    = 1'b1;
                        n_ovalid = 1'b1;
                        n_odata  = '0;
                        n_olast  = 1'b0;
                        n_odone  = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else if (sk_inside) begin
                    if (out_free) begin
                        n_x     = sk_x;
                        n_y     = sk_y;
                        n_scan  = r_scan + 1'b1;
                        n_state = S_ADDR;
                    end
                end else begin
                    n_scan = sk_next;
                end
            end
            S_ADDR: begin
                n_ovalid = 1'b1;
                n_odata  = {r_emit, raster, cmow_pkg::DIM_W'(r_y), cmow_pkg::DIM_W'(r_x)};
                n_olast  = ({2'b00, emit_inc} >= r_total);
                n_odone  = 1'b0;
                n_fin    = ({2'b00, emit_inc} >= r_total);
                n_emit   = emit_inc;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_scan   <= '0;
            r_emit   <= '0;
            r_fin    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_scan   <= n_scan;
            r_emit   <= n_emit;
            r_fin    <= n_fin;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= n_total;
        r_x     <= n_x;
        r_y     <= n_y;
        r_odata <= n_odata;
        r_olast <= n_olast;
        r_odone <= n_odone;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_odone;

endmodule

>>> src/cmow_skip.sv
// ----------------------------------------------------------------------------
// cmow_skip
// Splits a scan position into x / y, tests it against the clipped rectangle
// and gives the scan position after the largest aligned block that lies
// wholly outside.
// ----------------------------------------------------------------------------
module cmow_skip #(
    parameter int COORD_BITS = 16
) (
    input  logic [2*COORD_BITS:0]   i_scan,
    input  logic [COORD_BITS:0]     i_ew,
    input  logic [COORD_BITS:0]     i_eh,
    output logic [COORD_BITS-1:0]   o_x,
    output logic [COORD_BITS-1:0]   o_y,
    output logic                    o_inside,
    output logic [2*COORD_BITS:0]   o_next
);

    localparam int SW  = 2 * COORD_BITS + 1;
    localparam int PXW = (COORD_BITS > 1) ? $clog2(COORD_BITS) : 1;
    localparam int BW  = $clog2(2 * COORD_BITS + 1);

    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] ew_m1;
    logic [COORD_BITS-1:0] eh_m1;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [PXW-1:0]        px;
    logic [PXW-1:0]        py;
    logic                  x_out;
    logic                  y_out;
    logic [BW-1:0]         bx;
    logic [BW-1:0]         by;
    logic [BW-1:0]         best;

    always_comb begin
        for (int j = 0; j < COORD_BITS; j++) begin
            x[j] = i_scan[2*j];
            y[j] = i_scan[2*j+1];
        end
    end

    assign x_out = ({1'b0, x} >= i_ew);
    assign y_out = ({1'b0, y} >= i_eh);

    // block of 2^s stays outside in x while s is at most the top differing bit
    assign ew_m1 = COORD_BITS'(i_ew - 1'b1);
    assign eh_m1 = COORD_BITS'(i_eh - 1'b1);
    assign dx    = x ^ ew_m1;
    assign dy    = y ^ eh_m1;

    always_comb begin
        px = '0;
        py = '0;
        for (int j = 0; j < COORD_BITS; j++) begin
            if (dx[j]) begin
                px = PXW'(j);
            end
            if (dy[j]) begin
                py = PXW'(j);
            end
        end
    end

    assign bx = BW'({px, 1'b0});
    assign by = BW'({py, 1'b1});

    always_comb begin
        if (y_out && (!x_out || (by > bx))) begin
            best = by;
        end else begin
            best = bx;
        end
    end

    assign o_x      = x;
    assign o_y      = y;
    assign o_inside = !x_out && !y_out;
    assign o_next   = (i_scan & ({SW{1'b1}} << best)) + (SW'(1) << best);

endmodule
